@@ rtl/core/prm_pkg.sv @@
`default_nettype none

package prm_pkg;

  // Sizes of the page space, the frame pool and the swap area.
  localparam int NUM_PAGES  = 256;
  localparam int NUM_FRAMES = 16;
  localparam int NUM_SLOTS  = 64;

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int IDX_W   = (FRAME_W > SLOT_W) ? FRAME_W : SLOT_W;
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int KIND_W  = 2;
  localparam int STATUS_W = 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNMAP  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT_REPL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MAP_FRAME  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MAP_SWAP   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ERROR      = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decide;
    logic walk_step;
    logic push;
    logic victim_write;
    logic emit;
  } prm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic need_walk;
    logic need_push;
    logic need_victim;
    logic walk_done;
  } prm_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/prm_dp.sv @@
`default_nettype none

module prm_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  prm_pkg::prm_cmd_t              cmd,
  output prm_pkg::prm_stat_t             stat,
  input  logic                           cfg_write,
  input  logic                           cfg_policy_lru,
  input  logic [prm_pkg::KIND_W-1:0]     in_kind,
  input  logic [prm_pkg::PAGE_W-1:0]     in_page,
  output logic [prm_pkg::STATUS_W-1:0]   out_status,
  output logic [prm_pkg::FRAME_W-1:0]    out_frame,
  output logic                           out_victim_valid,
  output logic [prm_pkg::PAGE_W-1:0]     out_victim_page,
  output logic [prm_pkg::SLOT_W-1:0]     out_victim_slot
);
  import prm_pkg::*;

  logic                  policy_lru;
  logic [KIND_W-1:0]     kind_q;
  logic [PAGE_W-1:0]     page_q;

  // Page table: mapped bits in flops, resident bit and index in memory.
  logic [NUM_PAGES-1:0]  mapped;
  logic [IDX_W:0]        pt_mem [NUM_PAGES];
  logic [IDX_W:0]        pt_rd;
  logic                  mapped_q;

  logic [PAGE_W-1:0]     owner [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] free_frames;
  logic [NUM_SLOTS-1:0]  free_slots;
  logic [FRAME_W-1:0]    age [NUM_FRAMES];
  logic [CNT_W-1:0]      order_count;

  logic [CNT_W-1:0]      wi;
  logic [CNT_W-1:0]      wj;
  logic [FRAME_W-1:0]    rm_frame;
  logic [FRAME_W-1:0]    push_frame;
  logic                  need_walk;
  logic                  need_push;
  logic                  need_victim;
  logic [PAGE_W-1:0]     victim_q;
  logic [IDX_W-1:0]      victim_idx_q;

  logic [STATUS_W-1:0]   res_status;
  logic [FRAME_W-1:0]    res_frame;
  logic                  res_vv;
  logic [PAGE_W-1:0]     res_vp;
  logic [SLOT_W-1:0]     res_vs;

  logic                  ff_found;
  logic [FRAME_W-1:0]    ff_idx;
  logic                  fs_found;
  logic [SLOT_W-1:0]     fs_idx;

  logic                  resident;
  logic [IDX_W-1:0]      idx;
  logic [FRAME_W-1:0]    vf;
  logic [PAGE_W-1:0]     victim;

  logic [STATUS_W-1:0]   d_status;
  logic [FRAME_W-1:0]    d_frame;
  logic                  d_vv;
  logic                  d_alloc_frame;
  logic                  d_alloc_slot;
  logic                  d_free_frame;
  logic                  d_free_slot;
  logic                  d_owner_write;
  logic [FRAME_W-1:0]    d_owner_frame;
  logic                  d_pt_write;
  logic [IDX_W:0]        d_pt_data;
  logic                  d_map_clr;
  logic                  d_walk;
  logic [FRAME_W-1:0]    d_rm_frame;
  logic                  d_push;
  logic [FRAME_W-1:0]    d_push_frame;
  logic                  d_victim;

  logic                  pt_we;
  logic [PAGE_W-1:0]     pt_wa;
  logic [IDX_W:0]        pt_wd;
  logic                  walk_done;
  logic                  walk_keep;

  // Lowest free frame and lowest free slot.
  always_comb begin
    ff_found = |free_frames;
    ff_idx   = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (free_frames[i]) ff_idx = FRAME_W'(i);
    end
  end

  always_comb begin
    fs_found = |free_slots;
    fs_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_slots[i]) fs_idx = SLOT_W'(i);
    end
  end

  assign resident = pt_rd[IDX_W];
  assign idx      = pt_rd[IDX_W-1:0];
  assign vf       = age[0];
  assign victim   = owner[vf];

  // Decision for the current request from its table entry.
  always_comb begin
    d_status      = ST_ERROR;
    d_frame       = '0;
    d_vv          = 1'b0;
    d_alloc_frame = 1'b0;
    d_alloc_slot  = 1'b0;
    d_free_frame  = 1'b0;
    d_free_slot   = 1'b0;
    d_owner_write = 1'b0;
    d_owner_frame = ff_idx;
    d_pt_write    = 1'b0;
    d_pt_data     = {1'b1, IDX_W'(ff_idx)};
    d_map_clr     = 1'b0;
    d_walk        = 1'b0;
    d_rm_frame    = idx[FRAME_W-1:0];
    d_push        = 1'b0;
    d_push_frame  = ff_idx;
    d_victim      = 1'b0;
    case (kind_q)
      KIND_MAP: begin
        if (!mapped_q) begin
          if (ff_found) begin
            d_status      = ST_MAP_FRAME;
            d_frame       = ff_idx;
            d_alloc_frame = 1'b1;
            d_owner_write = 1'b1;
            d_push        = 1'b1;
            d_pt_write    = 1'b1;
          end else if (fs_found) begin
            d_status     = ST_MAP_SWAP;
            d_alloc_slot = 1'b1;
            d_pt_write   = 1'b1;
            d_pt_data    = {1'b0, IDX_W'(fs_idx)};
          end else begin
            d_status = ST_FULL;
          end
        end
      end
      KIND_UNMAP: begin
        if (mapped_q) begin
          d_status  = ST_RELEASED;
          d_map_clr = 1'b1;
          if (resident) begin
            d_free_frame = 1'b1;
            d_walk       = 1'b1;
          end else begin
            d_free_slot = 1'b1;
          end
        end
      end
      KIND_ACCESS: begin
        if (mapped_q) begin
          if (resident) begin
            d_status     = ST_HIT;
            d_frame      = idx[FRAME_W-1:0];
            d_walk       = policy_lru;
            d_push       = policy_lru;
            d_push_frame = idx[FRAME_W-1:0];
          end else if (ff_found) begin
            d_status      = ST_FAULT_FREE;
            d_frame       = ff_idx;
            d_alloc_frame = 1'b1;
            d_free_slot   = 1'b1;
            d_owner_write = 1'b1;
            d_push        = 1'b1;
            d_pt_write    = 1'b1;
          end else if (order_count != '0) begin
            d_status      = ST_FAULT_REPL;
            d_frame       = vf;
            d_vv          = 1'b1;
            d_walk        = 1'b1;
            d_rm_frame    = vf;
            d_push        = 1'b1;
            d_push_frame  = vf;
            d_victim      = 1'b1;
            d_owner_write = 1'b1;
            d_owner_frame = vf;
            d_pt_write    = 1'b1;
            d_pt_data     = {1'b1, IDX_W'(vf)};
          end
        end
      end
      default: d_status = ST_ERROR;
    endcase
  end

  // Page table memory: one write port, registered read at accept.
  assign pt_we = (cmd.decide && d_pt_write) || cmd.victim_write;
  assign pt_wa = cmd.victim_write ? victim_q : page_q;
  assign pt_wd = cmd.victim_write ? {1'b0, victim_idx_q} : d_pt_data;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    if (cmd.accept) pt_rd <= pt_mem[in_page];
  end

  // Request capture and decision payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= in_kind;
      page_q   <= in_page;
      mapped_q <= mapped[in_page];
    end
    if (cmd.decide) begin
      res_status   <= d_status;
      res_frame    <= d_frame;
      res_vv       <= d_vv;
      res_vp       <= d_vv ? victim : '0;
      res_vs       <= d_vv ? idx[SLOT_W-1:0] : '0;
      rm_frame     <= d_rm_frame;
      push_frame   <= d_push_frame;
      victim_q     <= victim;
      victim_idx_q <= idx;
      if (d_owner_write) owner[d_owner_frame] <= page_q;
    end
    if (cmd.emit) begin
      out_status       <= res_status;
      out_frame        <= res_frame;
      out_victim_valid <= res_vv;
      out_victim_page  <= res_vp;
      out_victim_slot  <= res_vs;
    end
  end

  // Allocation state, policy and mapped bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_lru  <= 1'b0;
      mapped      <= '0;
      free_frames <= '1;
      free_slots  <= '1;
      need_walk   <= 1'b0;
      need_push   <= 1'b0;
      need_victim <= 1'b0;
    end else begin
      if (cfg_write) policy_lru <= cfg_policy_lru;
      if (cmd.decide) begin
        need_walk   <= d_walk;
        need_push   <= d_push;
        need_victim <= d_victim;
        if (d_pt_write) mapped[page_q] <= 1'b1;
        if (d_map_clr) mapped[page_q] <= 1'b0;
        if (d_alloc_frame) free_frames[ff_idx] <= 1'b0;
        if (d_free_frame) free_frames[idx[FRAME_W-1:0]] <= 1'b1;
        if (d_alloc_slot) free_slots[fs_idx] <= 1'b0;
        if (d_free_slot) free_slots[idx[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  // Age order: compaction walk removes one frame, push appends at the young end.
  assign walk_done = (wi == order_count);
  assign walk_keep = (age[wi[FRAME_W-1:0]] != rm_frame);

  always_ff @(posedge clk) begin
    if (cmd.walk_step && !walk_done && walk_keep) begin
      age[wj[FRAME_W-1:0]] <= age[wi[FRAME_W-1:0]];
    end
    if (cmd.push && order_count < CNT_W'(NUM_FRAMES)) begin
      age[order_count[FRAME_W-1:0]] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_count <= '0;
      wi          <= '0;
      wj          <= '0;
    end else begin
      if (cmd.decide) begin
        wi <= '0;
        wj <= '0;
      end
      if (cmd.walk_step) begin
        if (walk_done) begin
          order_count <= wj;
        end else begin
          wi <= wi + 1'b1;
          if (walk_keep) wj <= wj + 1'b1;
        end
      end
      if (cmd.push && order_count < CNT_W'(NUM_FRAMES)) begin
        order_count <= order_count + 1'b1;
      end
    end
  end

  assign stat.need_walk   = need_walk;
  assign stat.need_push   = need_push;
  assign stat.need_victim = need_victim;
  assign stat.walk_done   = walk_done;

  // Every frame is either free or in the age order once a request completes.
  a_frames_accounted: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ($countones(free_frames) + int'(order_count) == NUM_FRAMES))
    else $error("frame bookkeeping out of balance");

  a_order_bounded: assert property (@(posedge clk) disable iff (rst)
    order_count <= CNT_W'(NUM_FRAMES))
    else $error("age order overflow");

  a_walk_pointers: assert property (@(posedge clk) disable iff (rst)
    (wj <= wi) && (wi <= order_count || !cmd.walk_step))
    else $error("compaction pointers out of order");

endmodule

`default_nettype wire

@@ rtl/core/prm_ctrl.sv @@
`default_nettype none

module prm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output prm_pkg::prm_cmd_t  cmd,
  input  prm_pkg::prm_stat_t stat
);
  import prm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_VICT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Commands for the datapath.
  always_comb begin
    cmd              = '0;
    cmd.accept       = (state == S_IDLE) && in_valid;
    cmd.decide       = (state == S_LOOK);
    cmd.walk_step    = (state == S_WALK) && stat.need_walk;
    cmd.push         = (state == S_PUSH) && stat.need_push;
    cmd.victim_write = (state == S_VICT) && stat.need_victim;
    cmd.emit         = (state == S_DONE) && (!out_valid || !out_stall);
  end

  // Sequencing of one request.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOOK;
      S_LOOK: state_next = S_WALK;
      S_WALK: if (!stat.need_walk || stat.walk_done) state_next = S_PUSH;
      S_PUSH: state_next = S_VICT;
      S_VICT: state_next = S_DONE;
      S_DONE: if (cmd.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A request is taken only when the previous one has fully finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

endmodule

`default_nettype wire

@@ rtl/core/page_replacement_manager_top.sv @@
`default_nettype none

// Page replacement manager: page table over virtual pages, physical frames and
// swap slots, with FIFO or LRU victim choice.
// Input channel: in_valid/in_stall with kind and virtual_page. A request is taken
// when in_valid is high and in_stall is low; one request is in flight at a time.
// Output channel: out_valid/out_stall with status, frame and victim fields, one
// result per request, held stable while out_stall is high.
// Configuration: cfg_valid/cfg_ready with cfg_policy_lru; cfg_ready is always high.
// A request passes from accept through the LOOK, WALK, PUSH, VICT and DONE states;
// when a frame is removed from the age order, the compaction walk in WALK visits
// one order entry per cycle. A new request is taken only after the last result is
// emitted. The page table memory has one write port, so a replacement updates the
// evicted page's entry in the VICT state, after the decision wrote the new entry.
// A stalled result keeps the block from finishing the next request, but the next
// request is taken as soon as the result has moved into the output register.
// Reset (rst, synchronous) unmaps all pages, frees all frames and slots, empties
// the age order and selects FIFO.

module page_replacement_manager_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prm_pkg::KIND_W-1:0]      kind,
  input  logic [prm_pkg::PAGE_W-1:0]      virtual_page,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prm_pkg::STATUS_W-1:0]    status,
  output logic [prm_pkg::FRAME_W-1:0]     frame,
  output logic                            victim_valid,
  output logic [prm_pkg::PAGE_W-1:0]      victim_page,
  output logic [prm_pkg::SLOT_W-1:0]      victim_slot,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_policy_lru
);
  import prm_pkg::*;

  prm_cmd_t  cmd;
  prm_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  prm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Tables, allocation flags and age order.
  prm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_policy_lru   (cfg_policy_lru),
    .in_kind          (kind),
    .in_page          (virtual_page),
    .out_status       (status),
    .out_frame        (frame),
    .out_victim_valid (victim_valid),
    .out_victim_page  (victim_page),
    .out_victim_slot  (victim_slot)
  );

endmodule

`default_nettype wire
